>>> rtl/symtab_pkg.sv
// Shared types and constants for the symbol table lookup/insert block.
// Used by every module in rtl/; depends on nothing else.
package symtab_pkg;

  localparam int unsigned TABLE_ENTRIES  = 128;
  localparam int unsigned MAX_NAME_CHARS = 19;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned ADDR_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W          = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CPOS_W         = $clog2(MAX_NAME_CHARS);
  localparam int unsigned LEN_W          = $clog2(MAX_NAME_CHARS + 1);
  localparam int unsigned INDEX_W        = 7;

  typedef logic [MAX_NAME_CHARS-1:0][CHAR_W-1:0] name_t;

  typedef enum logic [1:0] {
    STAT_FOUND    = 2'd0,
    STAT_INSERTED = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH
  } ctrl_state_e;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } ram_req_t;

endpackage

>>> rtl/symtab_name_buf.sv
// Collects the characters of the current name, zero-padded.
// Depends on symtab_pkg.
module symtab_name_buf (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [symtab_pkg::CHAR_W-1:0] char_i,
  input  logic                         clear_i,
  output symtab_pkg::name_t            name_o,
  output logic                         too_long_o
);

  symtab_pkg::name_t                  buf_q, buf_d;
  logic [symtab_pkg::LEN_W-1:0]       len_q, len_d;
  logic                               long_q, long_d;

  always_comb begin
    buf_d  = buf_q;
    len_d  = len_q;
    long_d = long_q;
    if (clear_i) begin
      buf_d  = '0;
      len_d  = '0;
      long_d = 1'b0;
    end else if (load_i) begin
      if (len_q < symtab_pkg::LEN_W'(symtab_pkg::MAX_NAME_CHARS)) begin
        buf_d[len_q[symtab_pkg::CPOS_W-1:0]] = char_i;
        len_d = len_q + 1'b1;
      end else begin
        long_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      len_q  <= '0;
      long_q <= 1'b0;
    end else begin
      buf_q  <= buf_d;
      len_q  <= len_d;
      long_q <= long_d;
    end
  end

  assign name_o     = buf_q;
  assign too_long_o = long_q;

endmodule

>>> rtl/symtab_ram.sv
// Storage for the table of names: one write port, one read port, registered read.
// Depends on symtab_pkg.
module symtab_ram (
  input  logic                 clk_i,
  input  symtab_pkg::ram_req_t req_i,
  input  symtab_pkg::name_t    wdata_i,
  output symtab_pkg::name_t    rdata_o
);

  symtab_pkg::name_t mem [symtab_pkg::TABLE_ENTRIES];
  symtab_pkg::name_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/symtab_ctrl.sv
// Search/insert sequencer: walks the stored entries, compares, appends, reports.
// Depends on symtab_pkg.
module symtab_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                last_i,
  input  logic                                too_long_i,
  input  symtab_pkg::name_t                   name_i,
  input  symtab_pkg::name_t                   rdata_i,
  output symtab_pkg::ram_req_t                req_o,
  output logic                                clear_o,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [symtab_pkg::INDEX_W-1:0]      index_o,
  output symtab_pkg::status_e                 status_o
);

  symtab_pkg::ctrl_state_e            state_q, state_d;
  logic [symtab_pkg::CNT_W-1:0]       count_q, count_d;
  logic [symtab_pkg::CNT_W-1:0]       k_q, k_d;
  logic                               pend_q, pend_d;
  logic [symtab_pkg::ADDR_W-1:0]      pidx_q, pidx_d;
  logic                               done_q, done_d;
  logic [symtab_pkg::INDEX_W-1:0]     index_q, index_d;
  symtab_pkg::status_e                status_q, status_d;

  logic hit, more, table_full;

  assign hit        = pend_q && (rdata_i == name_i);
  assign more       = k_q < count_q;
  assign table_full = count_q == symtab_pkg::CNT_W'(symtab_pkg::TABLE_ENTRIES);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      symtab_pkg::ST_IDLE: begin
        if (accept_i && last_i) state_d = symtab_pkg::ST_CHECK;
      end
      symtab_pkg::ST_CHECK: begin
        state_d = too_long_i ? symtab_pkg::ST_IDLE : symtab_pkg::ST_SEARCH;
      end
      symtab_pkg::ST_SEARCH: begin
        if (hit || (!pend_q && !more)) state_d = symtab_pkg::ST_IDLE;
      end
      default: state_d = symtab_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    req_o    = '0;
    clear_o  = 1'b0;
    count_d  = count_q;
    k_d      = k_q;
    pend_d   = pend_q;
    pidx_d   = pidx_q;
    done_d   = 1'b0;
    index_d  = index_q;
    status_d = status_q;
    unique case (state_q)
      symtab_pkg::ST_IDLE: begin
        if (accept_i && last_i) begin
          k_d    = '0;
          pend_d = 1'b0;
        end
      end
      symtab_pkg::ST_CHECK: begin
        if (too_long_i) begin
          done_d   = 1'b1;
          index_d  = '0;
          status_d = symtab_pkg::STAT_TOO_LONG;
          clear_o  = 1'b1;
        end
      end
      symtab_pkg::ST_SEARCH: begin
        if (hit) begin
          done_d   = 1'b1;
          index_d  = symtab_pkg::INDEX_W'(pidx_q);
          status_d = symtab_pkg::STAT_FOUND;
          clear_o  = 1'b1;
          pend_d   = 1'b0;
        end else if (more) begin
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = k_q[symtab_pkg::ADDR_W-1:0];
          pend_d        = 1'b1;
          pidx_d        = k_q[symtab_pkg::ADDR_W-1:0];
          k_d           = k_q + 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          done_d  = 1'b1;
          clear_o = 1'b1;
          if (table_full) begin
            index_d  = '0;
            status_d = symtab_pkg::STAT_FULL;
          end else begin
            req_o.wr_en   = 1'b1;
            req_o.wr_addr = count_q[symtab_pkg::ADDR_W-1:0];
            index_d       = symtab_pkg::INDEX_W'(count_q[symtab_pkg::ADDR_W-1:0]);
            status_d      = symtab_pkg::STAT_INSERTED;
            count_d       = count_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= symtab_pkg::ST_IDLE;
      count_q <= '0;
      k_q     <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q   <= pidx_d;
    index_q  <= index_d;
    status_q <= status_d;
  end

  assign busy_o   = state_q != symtab_pkg::ST_IDLE;
  assign done_o   = done_q;
  assign index_o  = index_q;
  assign status_o = status_q;

endmodule

>>> rtl/symbol_table_lookup_insert_core.sv
// Top level of the symbol table lookup/insert block.
// Depends on symtab_pkg, symtab_name_buf, symtab_ram and symtab_ctrl.
//
// Usage: a name is sent one character per transaction on name_char_i, with
// last_char_i high on its final character. A transaction is accepted at a
// rising clock edge where start_i is high and busy_o is low.
// Characters that are not final are taken one per cycle and busy_o stays low.
// On the final character the block raises busy_o and searches the stored
// names in insertion order, reading one table entry per cycle from a
// synchronous memory with a registered read.
// A result transaction is shown on entry_index_o and status_o for exactly
// one cycle, marked by done_o; the receiver cannot stall it.
// done_o is registered. After the final character the sequencer enters its
// check state, then walks the stored entries in its search state until a
// match or the end of the entries, and then inserts the name or reports a
// full table; an overlong name is answered from the check state. busy_o falls
// as done_o rises, so throughput is set by the linear walk over the table memory.
// Reset clears the entry count and the name buffer; the table memory itself
// is not cleared, and only entries below the count are ever read.
module symbol_table_lookup_insert_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [symtab_pkg::CHAR_W-1:0]     name_char_i,
  input  logic                              last_char_i,
  output logic                              done_o,
  output logic [symtab_pkg::INDEX_W-1:0]    entry_index_o,
  output logic [1:0]                        status_o
);

  symtab_pkg::name_t    name, rdata;
  symtab_pkg::ram_req_t ram_req;
  symtab_pkg::status_e  status;
  logic                 accept, clear, too_long;

  // A character transaction is taken whenever the sequencer is idle.
  assign accept = start_i && !busy_o;

  symtab_name_buf u_name_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .char_i     (name_char_i),
    .clear_i    (clear),
    .name_o     (name),
    .too_long_o (too_long)
  );

  symtab_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .wdata_i (name),
    .rdata_o (rdata)
  );

  symtab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .last_i     (last_char_i),
    .too_long_i (too_long),
    .name_i     (name),
    .rdata_i    (rdata),
    .req_o      (ram_req),
    .clear_o    (clear),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .index_o    (entry_index_o),
    .status_o   (status)
  );

  assign status_o = status;

endmodule

>>> tb/symbol_table_lookup_insert_core_checker.sv
// Checker for the symbol table lookup/insert core: predicts each name's answer and compares it.
// Depends on symtab_pkg; instantiated by symbol_table_lookup_insert_core_tb beside the block.
module symbol_table_lookup_insert_core_checker
  import symtab_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_o,
  input  logic [CHAR_W-1:0]   name_char_i,
  input  logic                last_char_i,
  input  logic                done_o,
  input  logic [INDEX_W-1:0]  entry_index_o,
  input  logic [1:0]          status_o,
  output int                  mismatch_count,
  output int                  pending_answers,
  output int                  found_count,
  output int                  inserted_count,
  output int                  full_count,
  output int                  too_long_count
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    status_e            status;
  } lookup_answer_t;

  lookup_answer_t answer_fifo[$];

  // Model of the block's own state.
  name_t name_buf;
  int    name_len;
  bit    name_overflow;
  name_t table_names[TABLE_ENTRIES];
  int    table_count;

  int errors;
  int n_found, n_inserted, n_full, n_too_long;

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_answer_t want;
    int             hit_index;
    if (!rst_ni) begin
      answer_fifo.delete();
      name_buf      = '0;
      name_len      = 0;
      name_overflow = 1'b0;
      table_count   = 0;
      errors        = 0;
      n_found       = 0;
      n_inserted    = 0;
      n_full        = 0;
      n_too_long    = 0;
    end else begin
      // Answers are compared before the character of this edge is taken in.
      if (done_o) begin
        if (answer_fifo.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: answer with no name pending: index %0d status %0d",
                     $realtime, entry_index_o, status_o);
        end else begin
          want = answer_fifo.pop_front();
          if (entry_index_o !== want.index || status_o !== want.status) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: answer mismatch: expected index %0d status %s, got index %0d status %0d",
                       $realtime, want.index, want.status.name(), entry_index_o, status_o);
          end
        end
      end

      if (start_i && !busy_o) begin
        if (name_len < MAX_NAME_CHARS) begin
          name_buf[name_len] = name_char_i;
          name_len++;
        end else begin
          name_overflow = 1'b1;
        end

        if (last_char_i) begin
          if (name_overflow) begin
            want = '{index: '0, status: STAT_TOO_LONG};
            n_too_long++;
          end else begin
            hit_index = -1;
            for (int k = 0; k < table_count; k++)
              if (hit_index < 0 && table_names[k] == name_buf)
                hit_index = k;
            if (hit_index >= 0) begin
              want = '{index: INDEX_W'(hit_index), status: STAT_FOUND};
              n_found++;
            end else if (table_count >= TABLE_ENTRIES) begin
              want = '{index: '0, status: STAT_FULL};
              n_full++;
            end else begin
              table_names[table_count] = name_buf;
              want = '{index: INDEX_W'(table_count), status: STAT_INSERTED};
              table_count++;
              n_inserted++;
            end
          end
          answer_fifo.push_back(want);
          name_buf      = '0;
          name_len      = 0;
          name_overflow = 1'b0;
        end
      end
    end

    mismatch_count  <= errors;
    pending_answers <= answer_fifo.size();
    found_count     <= n_found;
    inserted_count  <= n_inserted;
    full_count      <= n_full;
    too_long_count  <= n_too_long;
  end

endmodule

>>> tb/symbol_table_lookup_insert_core_tb.sv
// Testbench top for the symbol table lookup/insert core: drives names and gives the verdict.
// Depends on symtab_pkg, the RTL in rtl/ and symbol_table_lookup_insert_core_checker.
module symbol_table_lookup_insert_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import symtab_pkg::*;

  // The longest name the stimulus sends runs a few characters past the limit.
  localparam int MAX_SENT     = MAX_NAME_CHARS + 5;
  localparam int NAME_POOL    = 170;
  localparam int TARGET_CHARS = 2000;
  // Allow a wide margin for one full-table walk plus a long run of sender
  // idle cycles.
  localparam int STALL_LIMIT  = 8 * (TABLE_ENTRIES + 8) + 500;
  localparam int DRAIN_CYCLES = TABLE_ENTRIES + 16;

  typedef struct {
    int                len;
    logic [CHAR_W-1:0] chars [MAX_SENT];
  } test_name_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [CHAR_W-1:0]   name_char_i;
  logic                last_char_i;
  logic                done_o;
  logic [INDEX_W-1:0]  entry_index_o;
  logic [1:0]          status_o;

  int mismatch_count, pending_answers;
  int found_count, inserted_count, full_count, too_long_count;

  int chars_sent;
  int zero_chars_sent;
  int stall_cycles;

  test_name_t name_pool[NAME_POOL];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  symbol_table_lookup_insert_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .name_char_i   (name_char_i),
    .last_char_i   (last_char_i),
    .done_o        (done_o),
    .entry_index_o (entry_index_o),
    .status_o      (status_o)
  );

  symbol_table_lookup_insert_core_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .name_char_i     (name_char_i),
    .last_char_i     (last_char_i),
    .done_o          (done_o),
    .entry_index_o   (entry_index_o),
    .status_o        (status_o),
    .mismatch_count  (mismatch_count),
    .pending_answers (pending_answers),
    .found_count     (found_count),
    .inserted_count  (inserted_count),
    .full_count      (full_count),
    .too_long_count  (too_long_count)
  );

  // Watchdog: a cycle counts as progress when a character transaction is
  // accepted or an answer is presented. A long run without either is a hang.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Random name: mostly short, some close to the limit, a few too long.
  // Characters are nonzero except for an occasional zero code, which the
  // block stores as is and which then compares equal to padding.
  function automatic test_name_t random_name();
    test_name_t nm;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 80)      nm.len = $urandom_range(1, 8);
    else if (pick < 92) nm.len = $urandom_range(9, MAX_NAME_CHARS);
    else                nm.len = $urandom_range(MAX_NAME_CHARS + 1, MAX_SENT);
    for (int i = 0; i < MAX_SENT; i++)
      nm.chars[i] = ($urandom_range(0, 99) < 3) ? 8'h00 : CHAR_W'($urandom_range(1, 255));
    return nm;
  endfunction

  // Presents one character and holds it until the block accepts it. Called in
  // the time step of a rising edge; returns in the step of the accepting edge.
  // busy_o is read right after the edge, before the block updates it, so the
  // value seen is the one that decided acceptance.
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
    start_i     <= 1'b1;
    name_char_i <= ch;
    last_char_i <= last;
    do @(posedge clk_i); while (busy_o);
    chars_sent++;
    if (ch == 8'h00) zero_chars_sent++;
  endtask

  // Sends one whole name, with random sender idle cycles between characters
  // unless the run is inside its no-idle stretch.
  task automatic send_name(input test_name_t nm);
    bool_idle_loop: for (int i = 0; i < nm.len; i++) begin
      while (!(chars_sent >= 800 && chars_sent < 1200) && $urandom_range(0, 99) < 19) begin
        start_i     <= 1'b0;
        name_char_i <= CHAR_W'($urandom);
        last_char_i <= 1'($urandom);
        @(posedge clk_i);
      end
      send_char(nm.chars[i], i == nm.len - 1);
    end
  endtask

  initial begin
    test_name_t nm;
    int         pick;

    chars_sent      = 0;
    zero_chars_sent = 0;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    name_char_i <= '0;
    last_char_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed names. A single character is inserted at index 0, then found.
    nm.len = 1;
    nm.chars[0] = 8'h41;
    send_name(nm);
    send_name(nm);
    // The same name with a trailing zero matches the padded stored form.
    nm.len = 2;
    nm.chars[1] = 8'h00;
    send_name(nm);
    // Lowest character code.
    nm.len = 1;
    nm.chars[0] = 8'h01;
    send_name(nm);
    // A name of exactly the limit length, with character bits 6 to 0 toggling.
    nm.len = MAX_NAME_CHARS;
    for (int i = 0; i < MAX_SENT; i++) nm.chars[i] = (i % 2) ? 8'h80 : 8'hFF;
    send_name(nm);
    // One character past the limit is rejected as too long.
    nm.len = MAX_NAME_CHARS + 1;
    for (int i = 0; i < MAX_SENT; i++) nm.chars[i] = 8'h7F;
    send_name(nm);

    // Random part. A pool larger than the table supplies repeated names, so
    // lookups hit earlier entries; fresh names speed up filling the table,
    // after which new names come back as table full.
    for (int p = 0; p < NAME_POOL; p++) name_pool[p] = random_name();
    while (chars_sent < TARGET_CHARS) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) send_name(name_pool[$urandom_range(0, NAME_POOL - 1)]);
      else           send_name(random_name());
    end
    start_i <= 1'b0;

    // Wait for every predicted answer, then watch a little longer for strays.
    while (pending_answers != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d characters (%0d zero codes) forming %0d names.",
             chars_sent, zero_chars_sent,
             found_count + inserted_count + full_count + too_long_count);
    $display("Answers: %0d found, %0d inserted, %0d table full, %0d too long; %0d mismatches.",
             found_count, inserted_count, full_count, too_long_count, mismatch_count);
    if (mismatch_count == 0 && pending_answers == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> symbol_table_lookup_insert_core.f
rtl/symtab_pkg.sv
rtl/symtab_name_buf.sv
rtl/symtab_ram.sv
rtl/symtab_ctrl.sv
rtl/symbol_table_lookup_insert_core.sv
tb/symbol_table_lookup_insert_core_checker.sv
tb/symbol_table_lookup_insert_core_tb.sv
